// ===== sv/fcce_pkg.sv =====
// ----------------------------------------------------------------------------
// fcce_pkg
// Shared types and constants for the cluster chain engine.
// ----------------------------------------------------------------------------
package fcce_pkg;

    localparam int CL_W   = 14;
    localparam int LIM_W  = 15;
    localparam int WORD_W = 32;
    localparam int LINK_W = 28;
    localparam int IDX_W  = 2;

    localparam logic [LIM_W-1:0]  MAX_CLUSTERS  = 15'd16384;
    localparam logic [LINK_W-1:0] END_MARK      = 28'hFFFFFF8;
    localparam logic [WORD_W-1:0] COUNT_UNKNOWN = 32'hFFFFFFFF;

    localparam logic [IDX_W-1:0] REG_ROOT       = 2'd0;
    localparam logic [IDX_W-1:0] REG_COUNT      = 2'd1;
    localparam logic [IDX_W-1:0] REG_START_HINT = 2'd2;
    localparam logic [IDX_W-1:0] REG_START_FREE = 2'd3;

    typedef enum logic [1:0] {
        FUNC_WRITE   = 2'd0,
        FUNC_READ    = 2'd1,
        FUNC_ADVANCE = 2'd2,
        FUNC_WALK    = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_END     = 2'd1,
        ST_NO_FREE = 2'd2,
        ST_RANGE   = 2'd3
    } status_t;

    typedef struct packed {
        func_t              func;
        logic [CL_W-1:0]    cluster;
        logic [WORD_W-1:0]  entry_value;
        logic [LIM_W-1:0]   steps;
    } req_t;

    typedef struct packed {
        logic [WORD_W-1:0]  free_now;
        logic [WORD_W-1:0]  hint_now;
        logic [LINK_W-1:0]  result_cluster;
        status_t            status;
    } rsp_t;

    typedef struct packed {
        logic [CL_W-1:0]    root;
        logic [LIM_W-1:0]   limit;
    } cfg_t;

    typedef struct packed {
        logic               load;
        logic [WORD_W-1:0]  hint;
        logic [WORD_W-1:0]  free;
    } reload_t;

    typedef struct packed {
        logic               en;
        logic [CL_W-1:0]    addr;
        logic [WORD_W-1:0]  data;
    } tbl_wr_t;

endpackage

// ===== sv/fcce_table.sv =====
// ----------------------------------------------------------------------------
// fcce_table
// Cluster table storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module fcce_table
(
    input  logic                          clk,
    input  fcce_pkg::tbl_wr_t             wr,
    input  logic [fcce_pkg::CL_W-1:0]     rd_addr,
    output logic [fcce_pkg::WORD_W-1:0]   rd_data
);
    import fcce_pkg::*;

    localparam int DEPTH = 1 << CL_W;

    logic [WORD_W-1:0] entry_mem [DEPTH];
    logic [WORD_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            entry_mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= entry_mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/fcce_ctrl.sv =====
// ----------------------------------------------------------------------------
// fcce_ctrl
// Request sequencer: one cursor shared by
// reads, next-fit free search and chain walks; holds hint and free count.
// ----------------------------------------------------------------------------
module fcce_ctrl
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  fcce_pkg::cfg_t                cfg,
    input  fcce_pkg::reload_t             reload,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  fcce_pkg::req_t                in_req,
    input  logic                          out_free,
    output logic                          done,
    output fcce_pkg::rsp_t                rsp,
    output fcce_pkg::tbl_wr_t             tbl_wr,
    output logic [fcce_pkg::CL_W-1:0]     tbl_rd_addr,
    input  logic [fcce_pkg::WORD_W-1:0]   tbl_rd_data
);
    import fcce_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WRITE,
        S_ISSUE,
        S_CHECK,
        S_SCAN,
        S_LINK,
        S_MARK,
        S_RESP
    } state_t;

    state_t             state_reg,  state_next;
    func_t              func_reg,   func_next;
    logic [CL_W-1:0]    cl_reg,     cl_next;
    logic [WORD_W-1:0]  val_reg,    val_next;
    logic [LIM_W-1:0]   cnt_reg,    cnt_next;
    logic [LIM_W-1:0]   cur_reg,    cur_next;
    logic [LIM_W-1:0]   end_reg,    end_next;
    logic [LIM_W-1:0]   start_reg,  start_next;
    logic [LIM_W-1:0]   addrq_reg,  addrq_next;
    logic [LIM_W-1:0]   found_reg,  found_next;
    logic               pass_reg,   pass_next;
    logic               chk_reg,    chk_next;
    status_t            status_reg, status_next;
    logic [LINK_W-1:0]  res_reg,    res_next;
    logic [WORD_W-1:0]  hint_reg,   hint_next;
    logic [WORD_W-1:0]  free_reg,   free_next;

    logic [LINK_W-1:0]  link;
    logic [LIM_W-1:0]   root_ext;
    logic               hint_ok;

    assign link     = tbl_rd_data[LINK_W-1:0];
    assign root_ext = {1'b0, cfg.root};
    assign hint_ok  = (hint_reg >= WORD_W'(cfg.root)) && (hint_reg < WORD_W'(cfg.limit));

    always_comb
    begin
        state_next  = state_reg;
        func_next   = func_reg;
        cl_next     = cl_reg;
        val_next    = val_reg;
        cnt_next    = cnt_reg;
        cur_next    = cur_reg;
        end_next    = end_reg;
        start_next  = start_reg;
        addrq_next  = addrq_reg;
        found_next  = found_reg;
        pass_next   = pass_reg;
        chk_next    = chk_reg;
        status_next = status_reg;
        res_next    = res_reg;
        hint_next   = hint_reg;
        free_next   = free_reg;
        tbl_wr      = '0;
        in_ready    = 1'b0;
        done        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    func_next = in_req.func;
                    cl_next   = in_req.cluster;
                    val_next  = in_req.entry_value;
                    cnt_next  = in_req.steps;
                    cur_next  = {1'b0, in_req.cluster};
                    if ({1'b0, in_req.cluster} >= cfg.limit)
                    begin
                        status_next = ST_RANGE;
                        res_next    = LINK_W'(in_req.cluster);
                        state_next  = S_RESP;
                    end
                    else
                    begin
                        unique case (in_req.func)
                            FUNC_WRITE:
                            begin
                                state_next = S_WRITE;
                            end
                            FUNC_READ, FUNC_ADVANCE:
                            begin
                                state_next = S_ISSUE;
                            end
                            FUNC_WALK:
                            begin
                                if (in_req.steps == '0)
                                begin
                                    status_next = ST_OK;
                                    res_next    = LINK_W'(in_req.cluster);
                                    state_next  = S_RESP;
                                end
                                else
                                begin
                                    state_next = S_ISSUE;
                                end
                            end
                        endcase
                    end
                end
            end

            S_WRITE:
            begin
                tbl_wr.en   = 1'b1;
                tbl_wr.addr = cl_reg;
                tbl_wr.data = val_reg;
                status_next = ST_OK;
                res_next    = '0;
                state_next  = S_RESP;
            end

            S_ISSUE:
            begin
                state_next = S_CHECK;
            end

            S_CHECK:
            begin
                unique case (func_reg)
                    FUNC_READ:
                    begin
                        res_next    = link;
                        status_next = (link >= END_MARK) ? ST_END : ST_OK;
                        state_next  = S_RESP;
                    end
                    FUNC_ADVANCE:
                    begin
                        if (link < END_MARK)
                        begin
                            res_next    = link;
                            status_next = ST_OK;
                            state_next  = S_RESP;
                        end
                        else
                        begin
                            start_next = hint_ok ? hint_reg[LIM_W-1:0] : root_ext;
                            cur_next   = hint_ok ? hint_reg[LIM_W-1:0] : root_ext;
                            end_next   = cfg.limit;
                            pass_next  = 1'b0;
                            chk_next   = 1'b0;
                            state_next = S_SCAN;
                        end
                    end
                    FUNC_WALK:
                    begin
                        if (link >= END_MARK)
                        begin
                            status_next = ST_END;
                            res_next    = LINK_W'(cur_reg);
                            state_next  = S_RESP;
                        end
                        else if (link >= LINK_W'(cfg.limit))
                        begin
                            status_next = ST_RANGE;
                            res_next    = link;
                            state_next  = S_RESP;
                        end
                        else
                        begin
                            cur_next = link[LIM_W-1:0];
                            cnt_next = cnt_reg - 1'b1;
                            if (cnt_reg == LIM_W'(1))
                            begin
                                status_next = ST_OK;
                                res_next    = link;
                                state_next  = S_RESP;
                            end
                            else
                            begin
                                state_next = S_ISSUE;
                            end
                        end
                    end
                    FUNC_WRITE:
                    begin
                        state_next = S_RESP;
                    end
                endcase
            end

            S_SCAN:
            begin
                priority if (chk_reg && (link == '0))
                begin
                    found_next = addrq_reg;
                    chk_next   = 1'b0;
                    state_next = S_LINK;
                end
                else if (cur_reg < end_reg)
                begin
                    chk_next   = 1'b1;
                    addrq_next = cur_reg;
                    cur_next   = cur_reg + 1'b1;
                end
                else if (chk_reg)
                begin
                    chk_next = 1'b0;
                end
                else if (!pass_reg)
                begin
                    pass_next = 1'b1;
                    cur_next  = root_ext;
                    end_next  = start_reg;
                end
                else
                begin
                    status_next = ST_NO_FREE;
                    res_next    = '0;
                    state_next  = S_RESP;
                end
            end

            S_LINK:
            begin
                tbl_wr.en   = 1'b1;
                tbl_wr.addr = cl_reg;
                tbl_wr.data = WORD_W'(found_reg);
                state_next  = S_MARK;
            end

            S_MARK:
            begin
                tbl_wr.en   = 1'b1;
                tbl_wr.addr = found_reg[CL_W-1:0];
                tbl_wr.data = WORD_W'(END_MARK);
                hint_next   = WORD_W'(found_reg) + 32'd1;
                if ((free_reg != COUNT_UNKNOWN) && (free_reg != '0))
                begin
                    free_next = free_reg - 32'd1;
                end
                status_next = ST_OK;
                res_next    = LINK_W'(found_reg);
                state_next  = S_RESP;
            end

            S_RESP:
            begin
                done = 1'b1;
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (reload.load)
        begin
            hint_next = reload.hint;
            free_next = reload.free;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            func_reg   <= FUNC_WRITE;
            cl_reg     <= '0;
            val_reg    <= '0;
            cnt_reg    <= '0;
            cur_reg    <= '0;
            end_reg    <= '0;
            start_reg  <= '0;
            addrq_reg  <= '0;
            found_reg  <= '0;
            pass_reg   <= 1'b0;
            chk_reg    <= 1'b0;
            status_reg <= ST_OK;
            res_reg    <= '0;
            hint_reg   <= '0;
            free_reg   <= COUNT_UNKNOWN;
        end
        else
        begin
            state_reg  <= state_next;
            func_reg   <= func_next;
            cl_reg     <= cl_next;
            val_reg    <= val_next;
            cnt_reg    <= cnt_next;
            cur_reg    <= cur_next;
            end_reg    <= end_next;
            start_reg  <= start_next;
            addrq_reg  <= addrq_next;
            found_reg  <= found_next;
            pass_reg   <= pass_next;
            chk_reg    <= chk_next;
            status_reg <= status_next;
            res_reg    <= res_next;
            hint_reg   <= hint_next;
            free_reg   <= free_next;
        end
    end

    assign tbl_rd_addr        = cur_reg[CL_W-1:0];
    assign rsp.status         = status_reg;
    assign rsp.result_cluster = res_reg;
    assign rsp.hint_now       = hint_reg;
    assign rsp.free_now       = free_reg;

`ifndef ASSERT_OFF
    a_wr_states: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_wr.en |-> (state_reg == S_WRITE || state_reg == S_LINK || state_reg == S_MARK))
        else $error("table write outside a write state");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second request taken while busy");

    a_found_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MARK) |-> (found_reg < cfg.limit && found_reg >= root_ext))
        else $error("allocated cluster outside root..limit");

    a_free_step: assert property (@(posedge clk) disable iff (!rst_n)
        (!$stable(free_reg) && !$past(reload.load)) |-> (free_reg == $past(free_reg) - 32'd1))
        else $error("free count moved by more than one");
`endif

endmodule

// ===== sv/fat_cluster_chain_engine_unit.sv =====
// ----------------------------------------------------------------------------
// fat_cluster_chain_engine_unit
// Flow: write stores the entry; read, walk and advance read and check a link,
//   walk per link; unlinked advance scans one entry per cycle, up to two passes.
// Throughput: one request at a time; a new request is taken only in the idle state.
// Reset: async active low; config, hint and free count take reset values;
//   table contents are undefined until written, no clearing pass.
// ----------------------------------------------------------------------------
module fat_cluster_chain_engine_unit
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [fcce_pkg::IDX_W-1:0]      cfg_index,
    input  logic [fcce_pkg::WORD_W-1:0]     cfg_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // cluster[13:0], entry_value[45:14], steps[60:46], zero[63:61]
    input  logic [63:0]                     s_axis_tdata,
    // func[1:0]
    input  logic [1:0]                      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // status[1:0], result_cluster[29:2], hint_now[61:30], free_now[93:62], zero[95:94]
    output logic [95:0]                     m_axis_tdata
);
    import fcce_pkg::*;

    logic [CL_W-1:0]    root_reg;
    logic [LIM_W-1:0]   count_reg;
    logic [WORD_W-1:0]  start_hint_reg;
    logic [WORD_W-1:0]  start_free_reg;
    logic               m_valid_reg, m_valid_next;
    logic [95:0]        m_data_reg;

    cfg_t               cfg;
    reload_t            reload;
    req_t               req;
    rsp_t               rsp;
    tbl_wr_t            tbl_wr;
    logic [CL_W-1:0]    tbl_rd_addr;
    logic [WORD_W-1:0]  tbl_rd_data;
    logic               done;
    logic               out_free;
    logic               load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_reg       <= 14'd2;
            count_reg      <= MAX_CLUSTERS;
            start_hint_reg <= '0;
            start_free_reg <= COUNT_UNKNOWN;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ROOT:       root_reg       <= cfg_data[CL_W-1:0];
                REG_COUNT:      count_reg      <= cfg_data[LIM_W-1:0];
                REG_START_HINT: start_hint_reg <= cfg_data;
                REG_START_FREE: start_free_reg <= cfg_data;
            endcase
        end
    end

    assign cfg.root    = root_reg;
    assign cfg.limit   = (count_reg > MAX_CLUSTERS) ? MAX_CLUSTERS : count_reg;
    assign reload.load = cfg_we && (cfg_index == REG_START_HINT || cfg_index == REG_START_FREE);
    assign reload.hint = (cfg_index == REG_START_HINT) ? cfg_data : start_hint_reg;
    assign reload.free = (cfg_index == REG_START_FREE) ? cfg_data : start_free_reg;

    assign req.func        = func_t'(s_axis_tuser);
    assign req.cluster     = s_axis_tdata[13:0];
    assign req.entry_value = s_axis_tdata[45:14];
    assign req.steps       = s_axis_tdata[60:46];

    fcce_table u_table
    (
        .clk     (clk),
        .wr      (tbl_wr),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_data)
    );

    fcce_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .reload      (reload),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_req      (req),
        .out_free    (out_free),
        .done        (done),
        .rsp         (rsp),
        .tbl_wr      (tbl_wr),
        .tbl_rd_addr (tbl_rd_addr),
        .tbl_rd_data (tbl_rd_data)
    );

    assign out_free = !m_valid_reg || m_axis_tready;
    assign load     = done && out_free;

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (load)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            m_data_reg <= {2'b00, rsp.free_now, rsp.hint_now, rsp.result_cluster, rsp.status};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule
